@@ design/tks_pkg.sv @@
// tks_pkg: shared constants, operation codes and interface structs of the token scanner
// no dependencies; imported by tks_tables, tks_out_fifo, table_driven_token_scanner, tks_scan_checker and the testbench
`timescale 1ns / 1ps

package tks_pkg;

	localparam int STATES      = 256;
	localparam int CLASSES     = 16;
	localparam int MAX_INDICES = 64;

	localparam int SYM_W       = 8;
	localparam int ADDR_W      = 14;
	localparam int CLASS_DEPTH = 256;
	localparam int PAIR_DEPTH  = 256;
	localparam int TRANS_DEPTH = 16384;

	localparam int CLASS_AW = $clog2(CLASS_DEPTH);
	localparam int PAIR_AW  = $clog2(PAIR_DEPTH);
	localparam int TRANS_AW = $clog2(TRANS_DEPTH);
	localparam int CODE_AW  = $clog2(STATES);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ERROR = 2'd1;

	typedef enum logic [2:0] {
		OP_DATA     = 3'd0,
		OP_EOI      = 3'd1,
		OP_WR_CLASS = 3'd2,
		OP_WR_PAIR  = 3'd3,
		OP_WR_TRANS = 3'd4,
		OP_WR_CODE  = 3'd5
	} op_t;

	typedef struct packed {
		logic              en;
		op_t               op;
		logic [ADDR_W-1:0] addr;
		logic [SYM_W-1:0]  data;
	} tbl_wr_t;

	typedef struct packed {
		logic [CLASS_AW-1:0] class_addr;
		logic [PAIR_AW-1:0]  pair_addr;
		logic [TRANS_AW-1:0] trans_addr;
		logic [SYM_W-1:0]    code_state;
	} tbl_rd_t;

	typedef struct packed {
		logic [SYM_W-1:0] cls;
		logic [SYM_W-1:0] pair_idx;
		logic [SYM_W-1:0] next_state;
		logic [SYM_W-1:0] code;
	} tbl_rdata_t;

	typedef struct packed {
		logic [SYM_W-1:0] token_code;
		logic             rejected;
		logic             last;
	} res_t;

endpackage

@@ design/tks_tables.sv @@
// tks_tables: the four scanner tables as synchronous memories with registered reads
// depends on tks_pkg for depths, widths, operation codes and port structs
`timescale 1ns / 1ps

module tks_tables
	import tks_pkg::*;
(
	input  logic       clk,
	input  tbl_wr_t    wr,
	input  tbl_rd_t    rd,
	output tbl_rdata_t rdata
);

	logic [SYM_W-1:0] class_mem [CLASS_DEPTH];
	logic [SYM_W-1:0] pair_mem  [PAIR_DEPTH];
	logic [SYM_W-1:0] trans_mem [TRANS_DEPTH];
	logic [SYM_W-1:0] code_mem  [STATES];

	logic [ADDR_W:0]  wr_addr_x;
	logic             code_oob_q;
	logic [SYM_W-1:0] cls_rd_q;
	logic [SYM_W-1:0] pair_rd_q;
	logic [SYM_W-1:0] next_rd_q;
	logic [SYM_W-1:0] code_rd_q;

	assign wr_addr_x = {1'b0, wr.addr};

	always_ff @(posedge clk) begin
		if (wr.en) begin
			case (wr.op)
				OP_WR_CLASS: begin
					if (wr_addr_x < (ADDR_W+1)'(CLASS_DEPTH))
						class_mem[wr.addr[CLASS_AW-1:0]] <= wr.data;
				end
				OP_WR_PAIR: begin
					if (wr_addr_x < (ADDR_W+1)'(PAIR_DEPTH))
						pair_mem[wr.addr[PAIR_AW-1:0]] <= wr.data;
				end
				OP_WR_TRANS: begin
					if (wr_addr_x < (ADDR_W+1)'(TRANS_DEPTH))
						trans_mem[wr.addr[TRANS_AW-1:0]] <= wr.data;
				end
				OP_WR_CODE: begin
					if (wr_addr_x < (ADDR_W+1)'(STATES))
						code_mem[wr.addr[CODE_AW-1:0]] <= wr.data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cls_rd_q   <= class_mem[rd.class_addr];
		pair_rd_q  <= pair_mem[rd.pair_addr];
		next_rd_q  <= trans_mem[rd.trans_addr];
		code_rd_q  <= code_mem[rd.code_state[CODE_AW-1:0]];
		// states beyond the table carry code zero
		code_oob_q <= {1'b0, rd.code_state} >= (SYM_W+1)'(STATES);
	end

	assign rdata = '{
		cls:        cls_rd_q,
		pair_idx:   pair_rd_q,
		next_state: next_rd_q,
		code:       code_oob_q ? '0 : code_rd_q
	};

endmodule

@@ design/tks_out_fifo.sv @@
// tks_out_fifo: four-entry result queue between the scan engine and the output stream
// depends on tks_pkg for the result struct
`timescale 1ns / 1ps

module tks_out_fifo
	import tks_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_res,
	output logic room2,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	res_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             pop;

	assign out_valid = count_q != '0;
	assign out_res   = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign room2     = count_q <= (PTR_W+1)'(DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q < (PTR_W+1)'(DEPTH))
		else $error("result queue overflow");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> count_q == $past(count_q) - 1'b1)
		else $error("result queue count lost a transfer");

endmodule

@@ design/table_driven_token_scanner.sv @@
// table_driven_token_scanner: top level, input holding register, scan engine and config
// depends on tks_pkg, tks_tables and tks_out_fifo
//
//  channel | signals                                 | payload
//  s_      | s_tvalid s_tready s_tdata[31:0]         | operation, address, value
//  m_      | m_tvalid m_tready m_tdata m_tuser m_tlast| token_code, rejected, last
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data  | start_state (0), error_state (1)
//
// a data byte steps through S_PAIR, S_TRANS, S_DEC: class, pair index and transition reads
// chained through the tables, then the decision; a token end with a restart adds S_REPAIR,
// S_TRANS, S_DEC, a second reject S_REJ; end of input S_EOI; tables are written on take
// one item waits in the holding register while another is at work; results queue four deep
// and a new item starts only with room for two results in the queue
// reset clears control state; table contents are not cleared
`timescale 1ns / 1ps

module table_driven_token_scanner
	import tks_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,   // operation[2:0], address[16:3], value[24:17]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // token_code[7:0]
	output logic                 m_tuser,   // rejected[0]
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAIR,
		S_REPAIR,
		S_TRANS,
		S_DEC,
		S_REJ,
		S_EOI
	} scan_st_t;

	scan_st_t         state_q;
	logic             in_full_q;
	op_t              in_op_q;
	logic [ADDR_W-1:0] in_addr_q;
	logic [SYM_W-1:0] in_val_q;

	logic [SYM_W-1:0] start_q;
	logic [SYM_W-1:0] error_q;
	logic [SYM_W-1:0] scan_q;
	logic [SYM_W-1:0] prev_q;
	logic             tstart_q;
	logic [SYM_W-1:0] cls0_q;
	logic [SYM_W-1:0] cls_q;
	logic [SYM_W-1:0] code_hold_q;
	logic             pass2_q;

	logic             s_accept;
	logic             take;
	logic             room2;
	logic [SYM_W-1:0] st_eff;
	logic [SYM_W-1:0] pc_eff;
	logic [SYM_W-1:0] cls_sel;
	logic [15:0]      pair_full;
	logic [15:0]      trans_full;
	logic             push;
	res_t             push_res;
	res_t             out_res;
	tbl_wr_t          wr;
	tbl_rd_t          rd;
	tbl_rdata_t       rdata;

	assign cfg_ready = 1'b1;
	assign s_accept  = s_tvalid && s_tready;
	assign take      = in_full_q && state_q == S_IDLE && room2;
	assign s_tready  = !in_full_q || take;

	// token start stands in for start_state and the class of byte zero
	assign st_eff  = tstart_q ? start_q : scan_q;
	assign pc_eff  = tstart_q ? cls0_q : prev_q;
	assign cls_sel = (state_q == S_PAIR) ? rdata.cls : cls_q;

	assign pair_full  = 16'(pc_eff) * 16'(CLASSES) + 16'(cls_sel);
	assign trans_full = 16'(st_eff) * 16'(MAX_INDICES) + 16'(rdata.pair_idx);

	assign rd.class_addr = in_val_q[CLASS_AW-1:0];
	assign rd.pair_addr  = pair_full[PAIR_AW-1:0];
	assign rd.trans_addr = trans_full[TRANS_AW-1:0];
	assign rd.code_state = st_eff;

	assign wr.en   = take;
	assign wr.op   = in_op_q;
	assign wr.addr = in_addr_q;
	assign wr.data = in_val_q;

	always_comb begin
		push     = 1'b0;
		push_res = '0;
		case (state_q)
			S_DEC: begin
				if (rdata.next_state != error_q) begin
					push     = pass2_q;
					push_res = '{token_code: code_hold_q, rejected: 1'b0, last: 1'b1};
				end else if (pass2_q) begin
					push     = 1'b1;
					push_res = '{token_code: code_hold_q, rejected: 1'b0, last: 1'b0};
				end else if (tstart_q) begin
					push     = 1'b1;
					push_res = '{token_code: '0, rejected: 1'b1, last: 1'b1};
				end
			end
			S_REJ: begin
				push     = 1'b1;
				push_res = '{token_code: '0, rejected: 1'b1, last: 1'b1};
			end
			S_EOI: begin
				push     = 1'b1;
				push_res = '{token_code: rdata.code, rejected: 1'b0, last: 1'b1};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			in_op_q   <= op_t'(s_tdata[2:0]);
			in_addr_q <= s_tdata[16:3];
			in_val_q  <= s_tdata[24:17];
		end
		// shadow of class_table entry zero for token starts
		if (take && in_op_q == OP_WR_CLASS && in_addr_q == '0)
			cls0_q <= in_val_q;
		if (state_q == S_PAIR) begin
			cls_q       <= rdata.cls;
			code_hold_q <= rdata.code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 8'd1;
			error_q <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_START: start_q <= cfg_data;
				CFG_ERROR: error_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			in_full_q <= 1'b0;
			scan_q    <= 8'd1;
			prev_q    <= '0;
			tstart_q  <= 1'b1;
			pass2_q   <= 1'b0;
		end else begin
			if (s_accept)
				in_full_q <= 1'b1;
			else if (take)
				in_full_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take) begin
						pass2_q <= 1'b0;
						case (in_op_q)
							OP_DATA: state_q <= S_PAIR;
							OP_EOI:  state_q <= S_EOI;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_PAIR:   state_q <= S_TRANS;
				S_REPAIR: state_q <= S_TRANS;
				S_TRANS:  state_q <= S_DEC;
				S_DEC: begin
					if (rdata.next_state != error_q) begin
						scan_q   <= rdata.next_state;
						prev_q   <= cls_q;
						tstart_q <= 1'b0;
						state_q  <= S_IDLE;
					end else if (pass2_q) begin
						state_q <= S_REJ;
					end else if (tstart_q) begin
						state_q <= S_IDLE;
					end else begin
						// token ended: restart from the start state on the same byte
						tstart_q <= 1'b1;
						pass2_q  <= 1'b1;
						state_q  <= S_REPAIR;
					end
				end
				S_REJ: state_q <= S_IDLE;
				S_EOI: begin
					tstart_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	tks_tables u_tables (
		.clk   (clk),
		.wr    (wr),
		.rd    (rd),
		.rdata (rdata)
	);

	tks_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (push_res),
		.room2     (room2),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = out_res.token_code;
	assign m_tuser = out_res.rejected;
	assign m_tlast = out_res.last;

	a_reject_keeps_start: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_res.rejected) |=> tstart_q)
		else $error("rejected byte left the scanner off token start");

	a_repair_second_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REPAIR) |-> (pass2_q && tstart_q && $past(state_q) == S_DEC))
		else $error("restart pass entered without a finished token");

	a_rej_after_pass2: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REJ) |-> ($past(state_q) == S_DEC && $past(pass2_q)))
		else $error("second reject without a restart pass");

	a_take_room: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (room2 && !push))
		else $error("item started without room for its results");

endmodule

@@ test/tks_scan_checker.sv @@
// tks_scan_checker: watches the input, result and config channels of the token scanner,
// predicts every result from its own copy of the tables and scan state, and counts failures
// depends on tks_pkg
`timescale 1ns / 1ps

module tks_scan_checker
	import tks_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [31:0]          s_tdata,   // operation[2:0], address[16:3], value[24:17]
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [7:0]           m_tdata,   // token_code[7:0]
	input  logic                 m_tuser,   // rejected[0]
	input  logic                 m_tlast,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	output int                   fail_count,
	output int                   pending
);

	logic [7:0] start_q = 8'd1;
	logic [7:0] error_q = 8'd0;
	logic [7:0] scan_q = 8'd1;
	logic [7:0] prev_class_q = 8'd0;
	bit at_token_start = 1'b1;
	int fails = 0;
	int queued = 0;

	logic [7:0] class_tbl [CLASS_DEPTH];
	logic [7:0] pair_tbl [PAIR_DEPTH];
	logic [7:0] trans_tbl [TRANS_DEPTH];
	logic [7:0] code_tbl [STATES];

	res_t due_results [$];

	assign fail_count = fails;
	assign pending = queued;

	function automatic logic [7:0] code_for(input logic [7:0] st);
		return (int'(st) < STATES) ? code_tbl[st] : 8'd0;
	endfunction

	task automatic restart_token();
		at_token_start = 1'b1;
		scan_q = start_q;
		prev_class_q = class_tbl[0];
	endtask

	// one lookup chain: class, pair index, next state
	task automatic try_byte(input logic [7:0] b, output bit extended);
		logic [7:0] st;
		logic [7:0] pc;
		logic [7:0] cls;
		logic [7:0] idx;
		logic [7:0] nx;
		int pair_at;
		int trans_at;
		st = at_token_start ? start_q : scan_q;
		pc = at_token_start ? class_tbl[0] : prev_class_q;
		cls = class_tbl[b];
		pair_at = (int'(pc) * CLASSES + int'(cls)) % PAIR_DEPTH;
		idx = pair_tbl[pair_at[7:0]];
		trans_at = (int'(st) * MAX_INDICES + int'(idx)) % TRANS_DEPTH;
		nx = trans_tbl[trans_at[13:0]];
		extended = (nx != error_q);
		if (extended) begin
			scan_q = nx;
			prev_class_q = cls;
			at_token_start = 1'b0;
		end
	endtask

	task automatic add_result(input logic [7:0] code, input logic rej, input logic fin);
		res_t r;
		r.token_code = code;
		r.rejected = rej;
		r.last = fin;
		due_results.push_back(r);
	endtask

	task automatic scan_item(input logic [2:0] op, input logic [13:0] addr,
			input logic [7:0] val);
		bit ok;
		logic [7:0] ended;
		case (op)
			OP_DATA: begin
				try_byte(val, ok);
				if (!ok) begin
					// token ends here, the byte is tried again from the start state
					if (!at_token_start) begin
						ended = code_for(scan_q);
						restart_token();
						try_byte(val, ok);
						add_result(ended, 1'b0, ok);
					end
					if (!ok)
						add_result(8'd0, 1'b1, 1'b1);
				end
			end
			OP_EOI: begin
				add_result(code_for(at_token_start ? start_q : scan_q), 1'b0, 1'b1);
				restart_token();
			end
			OP_WR_CLASS: begin
				if (addr < CLASS_DEPTH)
					class_tbl[addr[7:0]] = val;
			end
			OP_WR_PAIR: begin
				if (addr < PAIR_DEPTH)
					pair_tbl[addr[7:0]] = val;
			end
			OP_WR_TRANS: begin
				if (addr < TRANS_DEPTH)
					trans_tbl[addr] = val;
			end
			OP_WR_CODE: begin
				if (addr < STATES && addr < 256)
					code_tbl[addr[7:0]] = val;
			end
			default: ;
		endcase
	endtask

	task automatic log_failure(input string what, input res_t want, input res_t got);
		fails++;
		if (fails <= 10)
			$display("%0t %s: expected code %0d rejected %0d last %0d, %s %0d %s %0d %s %0d",
				$time, what, want.token_code, want.rejected, want.last,
				"got code", got.token_code, "rejected", got.rejected, "last", got.last);
	endtask

	always @(posedge clk) begin : watch
		res_t got;
		res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.token_code = m_tdata;
				got.rejected = m_tuser;
				got.last = m_tlast;
				if (due_results.size() == 0) begin
					log_failure("result with nothing pending", '0, got);
				end else begin
					want = due_results.pop_front();
					if (got.token_code !== want.token_code || got.rejected !== want.rejected ||
							got.last !== want.last)
						log_failure("result mismatch", want, got);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_START)
					start_q = cfg_data;
				else if (cfg_index == CFG_ERROR)
					error_q = cfg_data;
			end
			if (s_tvalid && s_tready)
				scan_item(s_tdata[2:0], s_tdata[16:3], s_tdata[24:17]);
			queued = due_results.size();
		end
	end

endmodule

@@ test/table_driven_token_scanner_tb.sv @@
// table_driven_token_scanner_tb: loads scanner tables, sends directed and random bytes across
// several start/error settings with random stalls on both sides, and reports the verdict
// depends on tks_pkg, table_driven_token_scanner and tks_scan_checker
`timescale 1ns / 1ps

module table_driven_token_scanner_tb;
	import tks_pkg::*;

	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;
	localparam int PHASES = 5;
	localparam int RANDOM_PER_PHASE = 215;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int N_LIVE = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;   // operation[2:0], address[16:3], value[24:17]
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;         // token_code[7:0]
	logic m_tuser;               // rejected[0]
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	int fail_count;
	int pending;
	int drained = 0;
	int cycle_count = 0;

	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	logic [7:0] start_cfg = 8'd1;
	logic [7:0] error_cfg = 8'd0;
	logic [7:0] live_states [N_LIVE];
	logic [7:0] pair_codes [4];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	table_driven_token_scanner i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tks_scan_checker u_scan_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			drained <= drained + 1;
	end

	function automatic int gap_cycles(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [13:0] rand_addr(input int lo);
		return 14'($urandom_range(lo, 16383));
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] rand_code();
		return pair_codes[2'($urandom_range(0, 3))];
	endfunction

	function automatic logic [13:0] trans_slot(input logic [7:0] st, input logic [7:0] idx);
		return 14'((int'(st) * MAX_INDICES + int'(idx)) % TRANS_DEPTH);
	endfunction

	// next states are the error state or stay in the live set, so every reachable entry has been written
	function automatic logic [7:0] pick_target();
		if ($urandom_range(0, 9) < 3)
			return error_cfg;
		return live_states[3'($urandom_range(0, N_LIVE - 1))];
	endfunction

	task automatic put_item(input logic [2:0] op, input logic [13:0] addr, input logic [7:0] val);
		int gap;
		if ($urandom_range(0, 49) == 0)
			tx_calm = !tx_calm;
		gap = gap_cycles(tx_calm);
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, val, addr, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic put_config(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// all results in, then room for table writes still in flight
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic load_tables(input bit first);
		live_states[0] = start_cfg;
		for (int k = 1; k < N_LIVE; k++)
			live_states[3'(k)] = rand_byte();
		if (first) begin
			for (int a = 0; a < CLASS_DEPTH; a++)
				put_item(OP_WR_CLASS, 14'(a), rand_byte());
			for (int a = 0; a < PAIR_DEPTH; a++)
				put_item(OP_WR_PAIR, 14'(a), rand_code());
		end else begin
			repeat (16) put_item(OP_WR_CLASS, {6'd0, rand_byte()}, rand_byte());
			repeat (16) put_item(OP_WR_PAIR, {6'd0, rand_byte()}, rand_code());
		end
		for (int s = 0; s < N_LIVE; s++)
			for (int i = 0; i < 4; i++)
				put_item(OP_WR_TRANS, trans_slot(live_states[3'(s)], pair_codes[2'(i)]),
					pick_target());
		// make sure the start state both rejects some bytes and accepts others
		put_item(OP_WR_TRANS, trans_slot(start_cfg, pair_codes[0]), error_cfg);
		put_item(OP_WR_TRANS, trans_slot(start_cfg, pair_codes[1]), live_states[1]);
		for (int s = 0; s < N_LIVE; s++)
			put_item(OP_WR_CODE, {6'd0, live_states[3'(s)]}, rand_byte());
	endtask

	task automatic run_directed();
		put_item(OP_EOI, 14'd0, 8'h00);
		put_item(OP_EOI, 14'h3FFF, 8'hFF);
		put_item(OP_DATA, 14'd0, 8'h00);
		put_item(OP_DATA, 14'h3FFF, 8'hFF);
		put_item(OP_DATA, 14'h1555, 8'h55);
		put_item(OP_DATA, 14'h2AAA, 8'hAA);
		put_item(OP_DATA, 14'd0, 8'h00);
		put_item(OP_DATA, 14'd0, 8'hFF);
		put_item(OP_EOI, 14'd0, 8'h00);
		put_item(OP_SPARE6, 14'h3FFF, 8'hFF);
		put_item(OP_SPARE7, 14'd0, 8'h00);
		// writes past the end of the class, pair and code tables are dropped; the last trans entry is written
		put_item(OP_WR_CLASS, 14'h3FFF, 8'hFF);
		put_item(OP_WR_PAIR, 14'd256, 8'hFF);
		put_item(OP_WR_CODE, 14'h3FFF, 8'hFF);
		put_item(OP_WR_TRANS, 14'h3FFF, error_cfg);
		repeat (5) put_item(OP_DATA, rand_addr(0), rand_byte());
		put_item(OP_EOI, 14'd0, 8'h00);
	endtask

	task automatic run_random();
		int useful;
		int r;
		useful = 0;
		while (useful < RANDOM_PER_PHASE) begin
			r = $urandom_range(0, 99);
			useful++;
			if (r < 78) begin
				put_item(OP_DATA, rand_addr(0), rand_byte());
			end else if (r < 88) begin
				put_item(OP_EOI, rand_addr(0), rand_byte());
			end else if (r < 91) begin
				useful--;
				put_item($urandom_range(0, 1) ? OP_SPARE7 : OP_SPARE6,
					rand_addr(0), rand_byte());
			end else if (r < 93) begin
				put_item(OP_WR_CLASS, {6'd0, rand_byte()}, rand_byte());
			end else if (r < 95) begin
				put_item(OP_WR_PAIR, {6'd0, rand_byte()}, rand_code());
			end else if (r < 97) begin
				put_item(OP_WR_TRANS, rand_addr(0), pick_target());
			end else if (r < 99) begin
				put_item(OP_WR_CODE, rand_addr(0), rand_byte());
			end else begin
				useful--;
				case ($urandom_range(0, 2))
					0: put_item(OP_WR_CLASS, rand_addr(256), rand_byte());
					1: put_item(OP_WR_PAIR, rand_addr(256), rand_byte());
					default: put_item(OP_WR_CODE, rand_addr(256), rand_byte());
				endcase
			end
		end
	endtask

	// result side: random stalls plus two long hold-offs that back the block up
	initial begin : receiver
		int gap;
		int holds;
		int hold_at;
		holds = 0;
		hold_at = 150;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (holds < 2 && drained >= hold_at) begin
				holds++;
				hold_at = 900;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				if ($urandom_range(0, 49) == 0)
					rx_calm = !rx_calm;
				gap = gap_cycles(rx_calm);
				if (gap != 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			m_tready <= 1'b1;
			@(negedge clk);
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		pair_codes[0] = 8'd0;
		pair_codes[1] = 8'd63;
		pair_codes[2] = 8'd64;
		pair_codes[3] = 8'd255;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase != 0) begin
				// close the open token so the new start state takes over
				put_item(OP_EOI, rand_addr(0), rand_byte());
				wait_idle();
				case (phase)
					1: begin
						start_cfg = 8'd255;
						error_cfg = 8'd0;
					end
					2: begin
						start_cfg = 8'd0;
						error_cfg = 8'd255;
					end
					3: begin
						start_cfg = 8'($urandom_range(1, 254));
						error_cfg = 8'($urandom_range(1, 254));
					end
					default: begin
						start_cfg = rand_byte();
						error_cfg = start_cfg;
					end
				endcase
				put_config(CFG_START, start_cfg);
				put_config(CFG_ERROR, error_cfg);
			end
			load_tables(phase == 0);
			if (phase == 0)
				run_directed();
			run_random();
		end
		wait_idle();
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ files.f @@
design/tks_pkg.sv
design/tks_tables.sv
design/tks_out_fifo.sv
design/table_driven_token_scanner.sv
test/tks_scan_checker.sv
test/table_driven_token_scanner_tb.sv
